>>> rtl/bra_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap range allocator package
// Shared constants, command codes and the operation record that goes from
// the front end to the back end.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int MAP_BITS   = 1024;
  localparam int WORD_BITS  = 32;
  localparam int NUM_WORDS  = MAP_BITS / WORD_BITS;
  localparam int WIDX_W     = $clog2(NUM_WORDS);
  localparam int BIDX_W     = $clog2(WORD_BITS);
  localparam int POS_W      = 10;
  localparam int LEN_W      = 11;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    CMD_TEST,
    CMD_SET,
    CMD_CLEAR,
    CMD_FIND,
    CMD_FIND_SET,
    CMD_ALL,
    CMD_FILL,
    CMD_NOP
  } cmd_t;

  typedef enum logic [1:0] {
    OP_APPLY,
    OP_FIND,
    OP_FIND_SET
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic               is_test;
    logic               value;
    logic [LEN_W-1:0]   lo;
    logic [LEN_W-1:0]   hi;
    logic [POS_W-1:0]   position;
    logic [LEN_W-1:0]   run_length;
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_DONE
  } state_t;

endpackage

>>> rtl/bra_front.sv
// ----------------------------------------------------------------------------
// Bitmap range allocator front end
// Decodes an incoming command into an operation record with a clipped range.
// ----------------------------------------------------------------------------
module bra_front (
  input  logic [2:0]               command,
  input  logic                     fill_all,
  input  logic [bra_pkg::POS_W-1:0] position,
  input  logic [bra_pkg::LEN_W-1:0] run_length,
  input  logic [bra_pkg::LEN_W-1:0] size,
  output bra_pkg::op_t             op
);
  import bra_pkg::*;

  logic [LEN_W:0] range_end;
  logic [LEN_W-1:0] clip_end;

  assign range_end = {2'b00, position} + {1'b0, run_length};
  assign clip_end  = (range_end > {1'b0, size}) ? size : range_end[LEN_W-1:0];

  always_comb begin
    op            = '0;
    op.kind       = OP_APPLY;
    op.position   = position;
    op.run_length = run_length;
    unique case (cmd_t'(command))
      CMD_TEST: begin
        op.is_test = 1'b1;
      end
      CMD_SET: begin
        op.value = 1'b1;
        op.lo    = {1'b0, position};
        op.hi    = clip_end;
      end
      CMD_CLEAR: begin
        op.value = 1'b0;
        op.lo    = {1'b0, position};
        op.hi    = clip_end;
      end
      CMD_FIND: begin
        op.kind = OP_FIND;
        op.lo   = {1'b0, position};
      end
      CMD_FIND_SET: begin
        op.kind = OP_FIND_SET;
        op.lo   = {1'b0, position};
      end
      CMD_ALL: begin
        op.value = fill_all;
        op.hi    = size;
      end
      CMD_FILL: begin
        op.value = 1'b1;
        op.hi    = size;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/bra_queue.sv
// ----------------------------------------------------------------------------
// Bitmap range allocator operation queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bra_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  bra_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output bra_pkg::op_t pop_op
);
  import bra_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  op_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_op;
        wr_ptr          <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/bra_back.sv
// ----------------------------------------------------------------------------
// Bitmap range allocator back end
// Holds the bitmap, runs the word-wise first-fit scan and the update pass,
// and registers the result.
// ----------------------------------------------------------------------------
module bra_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [bra_pkg::LEN_W-1:0] size,
  input  logic                      q_valid,
  input  bra_pkg::op_t              q_op,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      found,
  output logic [bra_pkg::POS_W-1:0] run_index,
  output logic                      bit_value,
  output logic                      map_empty
);
  import bra_pkg::*;

  logic [WORD_BITS-1:0] map [NUM_WORDS];

  state_t            state;
  state_t            state_next;
  op_t               op;
  logic [WIDX_W-1:0] word_idx;
  logic [LEN_W-1:0]  zb;
  logic              hit;
  logic [LEN_W-1:0]  at;
  logic              any_set;
  logic              test_bit;

  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] eb;
  logic [LEN_W-1:0]     idx [WORD_BITS];
  logic [LEN_W-1:0]     zb_j [WORD_BITS];
  logic [WORD_BITS-1:0] cond;
  logic                 scan_hit;
  logic [LEN_W-1:0]     scan_at;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] active;
  logic [WORD_BITS-1:0] new_word;
  logic                 last_word;
  logic                 load_out;
  logic [LEN_W:0]       run_now;

  assign cur_word  = map[word_idx];
  assign last_word = (word_idx == WIDX_W'(NUM_WORDS - 1));
  assign load_out  = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      idx[j]    = {1'b0, word_idx, BIDX_W'(j)};
      eb[j]     = (idx[j] < op.lo) || (idx[j] >= size) || cur_word[j];
      mask[j]   = (idx[j] >= op.lo) && (idx[j] < op.hi);
      active[j] = (idx[j] < size);
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      zb_j[j] = zb;
      for (int k = 0; k <= j; k++) begin
        if (eb[k]) begin
          zb_j[j] = idx[k] + 1'b1;
        end
      end
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      run_now = {1'b0, idx[j]} + 1'b1 - {1'b0, zb_j[j]};
      cond[j] = (op.run_length != '0) && (run_now >= {1'b0, op.run_length});
    end
    scan_hit = 1'b0;
    scan_at  = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cond[j]) begin
        scan_hit = 1'b1;
        scan_at  = zb_j[j];
      end
    end
    new_word = op.value ? (cur_word | mask) : (cur_word & ~mask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = (q_op.kind == OP_APPLY) ? ST_APPLY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_hit || last_word) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (last_word) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        map[w] <= '0;
      end
      out_valid <= 1'b0;
      word_idx  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            op       <= q_op;
            word_idx <= '0;
            zb       <= {1'b0, q_op.position};
            hit      <= 1'b0;
            at       <= '0;
            any_set  <= 1'b0;
            test_bit <= 1'b0;
          end
        end
        ST_SCAN: begin
          zb <= zb_j[WORD_BITS-1];
          if (scan_hit || last_word) begin
            word_idx <= '0;
            op.value <= 1'b1;
            if (scan_hit && (op.kind == OP_FIND_SET)) begin
              op.lo <= scan_at;
              op.hi <= scan_at + op.run_length;
            end else begin
              op.lo <= '0;
              op.hi <= '0;
            end
          end else begin
            word_idx <= word_idx + 1'b1;
          end
          if (scan_hit) begin
            hit <= 1'b1;
            at  <= scan_at;
          end
        end
        ST_APPLY: begin
          map[word_idx] <= new_word;
          any_set       <= any_set | (|(new_word & active));
          word_idx      <= word_idx + 1'b1;
          if (op.is_test && (word_idx == op.position[POS_W-1:BIDX_W])
              && ({1'b0, op.position} < size)) begin
            test_bit <= cur_word[op.position[BIDX_W-1:0]];
          end
        end
        default: begin
        end
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
        found     <= hit;
        run_index <= hit ? at[POS_W-1:0] : '0;
        bit_value <= test_bit;
        map_empty <= !any_set;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/bitmap_range_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap range allocator
// First-fit contiguous allocator over a 1024-bit map with range set and clear,
// bit test, and whole-map clear and fill.
//
//   Channel   Handshake                 Payload
//   in        in_valid / in_stall       command, fill_all, position, run_length
//   out       out_valid / out_stall     found, run_index, bit_value, map_empty
//   cfg       cfg_write                 cfg_data (active_bits)
//
// Commands that do not search dequeue the operation, run the update pass word
// by word over the 32-bit words, and then register the result.
// Find commands first scan one word per cycle up to the first fit or last word.
// Synchronous reset clears the map and sets active_bits to 1024.
// A two-entry queue takes new items while the back end works or its result
// is stalled.
// ----------------------------------------------------------------------------
module bitmap_range_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic        fill_all,
  input  logic [9:0]  position,
  input  logic [10:0] run_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [9:0]  run_index,
  output logic        bit_value,
  output logic        map_empty
);
  import bra_pkg::*;

  logic [LEN_W-1:0] active_bits;
  logic [LEN_W-1:0] size;
  op_t              front_op;
  op_t              q_op;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bits <= LEN_W'(MAP_BITS);
    end else if (cfg_write) begin
      active_bits <= cfg_data;
    end
  end

  assign size     = (active_bits > LEN_W'(MAP_BITS)) ? LEN_W'(MAP_BITS) : active_bits;
  assign in_stall = q_full;

  bra_front u_front (
    .command    (command),
    .fill_all   (fill_all),
    .position   (position),
    .run_length (run_length),
    .size       (size),
    .op         (front_op)
  );

  bra_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_op   (front_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_op    (q_op)
  );

  bra_back u_back (
    .clk       (clk),
    .rst       (rst),
    .size      (size),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .run_index (run_index),
    .bit_value (bit_value),
    .map_empty (map_empty)
  );

endmodule

>>> test/bra_checker.sv
// ----------------------------------------------------------------------------
// Bitmap range allocator checker
// Watches the command and result channels, keeps a shadow allocation map
// and the active size, predicts each result, and compares it field by field.
// ----------------------------------------------------------------------------
module bra_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  command,
  input  logic        fill_all,
  input  logic [9:0]  position,
  input  logic [10:0] run_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        found,
  input  logic [9:0]  run_index,
  input  logic        bit_value,
  input  logic        map_empty,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bra_pkg::*;

  typedef struct packed {
    logic       found;
    logic [9:0] run_index;
    logic       bit_value;
    logic       map_empty;
  } alloc_result_t;

  logic [MAP_BITS-1:0] shadow_map;
  int unsigned shadow_size;
  alloc_result_t expected_results[$];

  function automatic int unsigned used_size();
    return (shadow_size > MAP_BITS) ? MAP_BITS : shadow_size;
  endfunction

  function automatic void mark_range(int unsigned start, int unsigned len, logic v);
    int unsigned stop;
    stop = start + len;
    if (stop > used_size()) stop = used_size();
    for (int unsigned i = start; i < stop; i++) shadow_map[i] = v;
  endfunction

  function automatic logic first_fit(int unsigned start, int unsigned len,
                                     output int unsigned at);
    int unsigned span;
    span = 0;
    at = 0;
    if (len == 0) return 1'b0;
    for (int unsigned i = start; i < used_size(); i++) begin
      if (shadow_map[i]) begin
        span = 0;
      end else begin
        span++;
        if (span == len) begin
          at = i + 1 - len;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic alloc_result_t apply_command(cmd_t cmd, logic fill,
                                                  int unsigned pos, int unsigned len);
    alloc_result_t r;
    int unsigned at;
    r = '0;
    case (cmd)
      CMD_TEST: begin
        if (pos < used_size()) r.bit_value = shadow_map[pos];
      end
      CMD_SET: mark_range(pos, len, 1'b1);
      CMD_CLEAR: mark_range(pos, len, 1'b0);
      CMD_FIND, CMD_FIND_SET: begin
        if (first_fit(pos, len, at)) begin
          r.found = 1'b1;
          r.run_index = at[9:0];
          if (cmd == CMD_FIND_SET) mark_range(at, len, 1'b1);
        end
      end
      CMD_ALL: mark_range(0, used_size(), fill);
      CMD_FILL: mark_range(0, used_size(), 1'b1);
      default: ;
    endcase
    r.map_empty = 1'b1;
    for (int unsigned i = 0; i < used_size(); i++)
      if (shadow_map[i]) r.map_empty = 1'b0;
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    alloc_result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      shadow_map = '0;
      shadow_size = MAP_BITS;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_write) shadow_size = cfg_data;
      if (in_valid && !in_stall)
        expected_results.push_back(apply_command(cmd_t'(command), fill_all,
                                                 position, run_length));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no command outstanding");
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            errs++;
          end
          if (run_index !== want.run_index) begin
            $error("run_index: expected %0d, got %0d", want.run_index, run_index);
            errs++;
          end
          if (bit_value !== want.bit_value) begin
            $error("bit_value: expected %0d, got %0d", want.bit_value, bit_value);
            errs++;
          end
          if (map_empty !== want.map_empty) begin
            $error("map_empty: expected %0d, got %0d", want.map_empty, map_empty);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

>>> test/tb_bitmap_range_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap range allocator testbench
// Drives directed and random allocator commands under several map sizes and
// idle patterns; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_bitmap_range_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import bra_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  command = '0;
  logic        fill_all = 1'b0;
  logic [9:0]  position = '0;
  logic [10:0] run_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        found;
  logic [9:0]  run_index;
  logic        bit_value;
  logic        map_empty;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bitmap_range_allocator dut (.*);
  bra_checker checker_i (.*);

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_command(cmd_t cmd, logic fill, logic [9:0] pos, logic [10:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    fill_all <= fill;
    position <= pos;
    run_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic resize_map(logic [10:0] size);
    drain();
    repeat (80) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= size;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_command(int unsigned size);
    int unsigned pick;
    logic [9:0] pos;
    logic [10:0] len;
    pick = $urandom_range(99);
    pos = (size > 0 && $urandom_range(9) != 0) ? 10'($urandom_range(size - 1))
                                               : 10'($urandom);
    len = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(24));
    if (pick < 30) send_command(CMD_FIND_SET, 1'b0, pos, len);
    else if (pick < 45) send_command(CMD_FIND, 1'b0, pos, len);
    else if (pick < 65) send_command(CMD_CLEAR, 1'b0, pos, len);
    else if (pick < 75) send_command(CMD_SET, 1'b0, pos, len);
    else if (pick < 93) send_command(CMD_TEST, 1'b0, pos, len);
    else if (pick < 96) send_command(CMD_ALL, 1'($urandom), pos, len);
    else if (pick < 98) send_command(CMD_FILL, 1'b0, pos, len);
    else send_command(CMD_NOP, 1'($urandom), pos, len);
  endtask

  initial begin
    int unsigned sizes [6] = '{1024, 1, 2047, 37, 1000, 0};
    send_idle_pct = 21;
    recv_idle_pct = 60;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_command(CMD_TEST, 1'b0, 10'd0, 11'd0);
    send_command(CMD_FIND_SET, 1'b0, 10'd0, 11'd1024);
    send_command(CMD_TEST, 1'b0, 10'd1023, 11'd0);
    send_command(CMD_CLEAR, 1'b0, 10'd1000, 11'd2047);
    send_command(CMD_FIND, 1'b0, 10'd1000, 11'd24);
    send_command(CMD_FIND_SET, 1'b0, 10'd1020, 11'd5);
    send_command(CMD_FIND, 1'b0, 10'd3, 11'd0);
    send_command(CMD_SET, 1'b0, 10'd5, 11'd0);
    send_command(CMD_SET, 1'b0, 10'd900, 11'd1024);
    send_command(CMD_FIND, 1'b0, 10'd0, 11'd1000);
    send_command(CMD_ALL, 1'b0, 10'd0, 11'd0);
    send_command(CMD_FILL, 1'b0, 10'd0, 11'd0);
    send_command(CMD_ALL, 1'b1, 10'h3FF, 11'h7FF);
    send_command(CMD_ALL, 1'b0, 10'h155, 11'h2AA);
    send_command(CMD_NOP, 1'b1, 10'h2AA, 11'h555);
    send_command(CMD_FIND_SET, 1'b0, 10'd0, 11'd1025);
    resize_map(11'd16);
    send_command(CMD_FILL, 1'b0, 10'd0, 11'd0);
    send_command(CMD_TEST, 1'b0, 10'd16, 11'd0);
    send_command(CMD_CLEAR, 1'b0, 10'd12, 11'd100);
    send_command(CMD_FIND, 1'b0, 10'd12, 11'd4);
    send_command(CMD_FIND, 1'b0, 10'd20, 11'd1);
    send_command(CMD_ALL, 1'b0, 10'd0, 11'd0);
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 60;
        recv_idle_pct = 21;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int s = 0; s < 6; s++) begin
        resize_map(11'(sizes[(s + 2 * phase) % 6]));
        for (int n = 0; n < 83; n++)
          random_command(sizes[(s + 2 * phase) % 6] > MAP_BITS ?
                         MAP_BITS : sizes[(s + 2 * phase) % 6]);
      end
    end
    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
